// ----- rtl/tkm_pkg.sv -----
// ---------------------------------------------------------------------------
// tkm_pkg: shared types and codes for the timestamp k-way merge
// Request, response and queued command layouts, status and request codes.
// ---------------------------------------------------------------------------
package tkm_pkg;

  localparam int CHANNELS_DEF   = 16;
  localparam int FIFO_DEPTH_DEF = 16;
  localparam int ENABLE_BITS    = 16;

  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_CLOSE = 2'd1;
  localparam logic [1:0] REQ_PULL  = 2'd2;

  localparam logic [2:0] ST_ACCEPTED  = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_EVENT     = 3'd2;
  localparam logic [2:0] ST_NOT_READY = 3'd3;
  localparam logic [2:0] ST_DONE      = 3'd4;
  localparam logic [2:0] ST_CLOSED    = 3'd5;

  localparam logic [63:0] SENTINEL = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [3:0] {
    OP_PUSH  = 4'b0001,
    OP_CLOSE = 4'b0010,
    OP_PULL  = 4'b0100,
    OP_NONE  = 4'b1000
  } op_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  channel;
    logic [63:0] timestamp;
    logic [15:0] long_gate;
    logic [15:0] short_gate;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  out_channel;
    logic [63:0] out_time;
    logic [15:0] out_long_gate;
    logic [15:0] out_short_gate;
  } rsp_t;

  typedef struct packed {
    op_t         op;
    logic        ch_ok;
    logic        sentinel;
    logic [3:0]  channel;
    logic [63:0] timestamp;
    logic [31:0] gates;
  } cmd_t;

endpackage

// ----- rtl/tkm_req_if.sv -----
// ---------------------------------------------------------------------------
// tkm_req_if: request channel
// Valid/ready channel carrying one request transaction.
// ---------------------------------------------------------------------------
interface tkm_req_if;
  logic          valid;
  logic          ready;
  tkm_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/tkm_rsp_if.sv -----
// ---------------------------------------------------------------------------
// tkm_rsp_if: response channel
// Valid/ready channel carrying one response transaction.
// ---------------------------------------------------------------------------
interface tkm_rsp_if;
  logic          valid;
  logic          ready;
  tkm_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/tkm_front.sv -----
// ---------------------------------------------------------------------------
// tkm_front: request intake
// Decode each request into a command and hold it in a two-entry queue.
// ---------------------------------------------------------------------------
module tkm_front #(
  parameter int CHANNELS = tkm_pkg::CHANNELS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  tkm_req_if.sink       req,
  output logic          cmd_valid,
  output tkm_pkg::cmd_t cmd,
  input  logic          cmd_pop
);
  import tkm_pkg::*;

  cmd_t       q [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       dec;
  logic       push;

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  always_comb begin
    dec.ch_ok     = (32'(req.data.channel) < 32'(CHANNELS));
    dec.sentinel  = (req.data.timestamp == SENTINEL);
    dec.channel   = req.data.channel;
    dec.timestamp = req.data.timestamp;
    dec.gates     = {req.data.long_gate, req.data.short_gate};
    case (req.data.req_type)
      REQ_PUSH:  dec.op = OP_PUSH;
      REQ_CLOSE: dec.op = OP_CLOSE;
      REQ_PULL:  dec.op = OP_PULL;
      default:   dec.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, cmd_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end
endmodule

// ----- rtl/tkm_back.sv -----
// ---------------------------------------------------------------------------
// tkm_back: command execution
// Per-channel FIFOs in one event store, sequential head scan for pulls.
// ---------------------------------------------------------------------------
module tkm_back #(
  parameter int CHANNELS   = tkm_pkg::CHANNELS_DEF,
  parameter int FIFO_DEPTH = tkm_pkg::FIFO_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [tkm_pkg::ENABLE_BITS-1:0] enable,
  input  logic                            cmd_valid,
  input  tkm_pkg::cmd_t                   cmd,
  output logic                            cmd_pop,
  tkm_rsp_if.source                       rsp
);
  import tkm_pkg::*;

  localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int AW = $clog2(CHANNELS * FIFO_DEPTH);
  localparam int MD = CHANNELS * FIFO_DEPTH;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_CMP  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t        state;
  logic [63:0]   time_mem [0:MD-1];
  logic [31:0]   gate_mem [0:MD-1];
  logic [63:0]   rd_time;
  logic [31:0]   rd_gate;
  logic [CW-1:0] fill [0:CHANNELS-1];
  logic [PW-1:0] head [0:CHANNELS-1];
  logic [CHANNELS-1:0] closed;
  logic [CHANNELS-1:0] en_ext;
  logic [IW-1:0] scan;
  logic [IW-1:0] best;
  logic          have;
  logic [63:0]   best_t;
  logic [31:0]   best_gate;
  logic          res_valid;
  rsp_t          res;

  logic [IW-1:0] idx;
  logic [CW-1:0] fill_i;
  logic [PW-1:0] head_i;
  logic [SW-1:0] slot;
  logic [AW-1:0] base;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          scan_last;
  logic          do_write;
  logic          do_read;

  // response with only a status, event fields zero
  function automatic rsp_t status_rsp(logic [2:0] code);
    rsp_t r;
    r        = '0;
    r.status = code;
    return r;
  endfunction

  for (genvar k = 0; k < CHANNELS; k++) begin : g_en
    if (k < ENABLE_BITS) begin : g_bit
      assign en_ext[k] = enable[k];
    end else begin : g_one
      assign en_ext[k] = 1'b1;
    end
  end

  always_comb begin
    case (state)
      S_IDLE:  idx = IW'(cmd.channel);
      S_FIN:   idx = best;
      default: idx = scan;
    endcase
    fill_i    = fill[idx];
    head_i    = head[idx];
    base      = AW'(AW'(idx) * AW'(FIFO_DEPTH));
    slot      = SW'(head_i) + SW'(fill_i);
    if (slot >= SW'(FIFO_DEPTH)) begin
      slot = slot - SW'(FIFO_DEPTH);
    end
    wr_addr   = base + AW'(slot);
    rd_addr   = base + AW'(head_i);
    scan_last = (scan == IW'(CHANNELS - 1));
    cmd_pop   = (state == S_IDLE) && cmd_valid && !res_valid;
    do_write  = cmd_pop && (cmd.op == OP_PUSH) && cmd.ch_ok && !closed[idx] &&
                en_ext[idx] && !cmd.sentinel && (fill_i != CW'(FIFO_DEPTH));
    do_read   = (state == S_SCAN) && en_ext[idx] && (fill_i != '0);
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      time_mem[wr_addr] <= cmd.timestamp;
      gate_mem[wr_addr] <= cmd.gates;
    end
    if (do_read) begin
      rd_time <= time_mem[rd_addr];
      rd_gate <= gate_mem[rd_addr];
    end
  end

  assign rsp.valid = res_valid;
  assign rsp.data  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      closed    <= '0;
      scan      <= '0;
      have      <= 1'b0;
      for (int k = 0; k < CHANNELS; k++) begin
        fill[k] <= '0;
        head[k] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            case (cmd.op)
              OP_PUSH: begin
                res_valid <= 1'b1;
                if (!cmd.ch_ok || closed[idx] || !en_ext[idx]) begin
                  res <= status_rsp(ST_CLOSED);
                end else if (cmd.sentinel) begin
                  res <= status_rsp(ST_ACCEPTED);
                end else if (fill_i == CW'(FIFO_DEPTH)) begin
                  res <= status_rsp(ST_FULL);
                end else begin
                  fill[idx] <= fill_i + CW'(1);
                  res       <= status_rsp(ST_ACCEPTED);
                end
              end
              OP_CLOSE: begin
                res_valid <= 1'b1;
                if (!cmd.ch_ok) begin
                  res <= status_rsp(ST_CLOSED);
                end else begin
                  closed[idx] <= 1'b1;
                  res         <= status_rsp(ST_ACCEPTED);
                end
              end
              OP_PULL: begin
                scan  <= '0;
                have  <= 1'b0;
                state <= S_SCAN;
              end
              default: begin
                res_valid <= 1'b1;
                res       <= status_rsp(ST_NOT_READY);
              end
            endcase
          end else if (rsp.ready) begin
            res_valid <= 1'b0;
          end
        end
        S_SCAN: begin
          if (en_ext[idx] && fill_i == '0 && !closed[idx]) begin
            res_valid <= 1'b1;
            res       <= status_rsp(ST_NOT_READY);
            state     <= S_IDLE;
          end else if (do_read) begin
            state <= S_CMP;
          end else if (scan_last) begin
            state <= S_FIN;
          end else begin
            scan <= scan + IW'(1);
          end
        end
        S_CMP: begin
          if (!have || rd_time < best_t) begin
            have      <= 1'b1;
            best      <= scan;
            best_t    <= rd_time;
            best_gate <= rd_gate;
          end
          if (scan_last) begin
            state <= S_FIN;
          end else begin
            scan  <= scan + IW'(1);
            state <= S_SCAN;
          end
        end
        S_FIN: begin
          res_valid <= 1'b1;
          state     <= S_IDLE;
          if (!have) begin
            res <= status_rsp(ST_DONE);
          end else begin
            head[idx] <= (head_i == PW'(FIFO_DEPTH - 1)) ? '0 : head_i + PW'(1);
            fill[idx] <= fill_i - CW'(1);
            res       <= '{status: ST_EVENT, out_channel: 4'(best), out_time: best_t,
                           out_long_gate: best_gate[31:16],
                           out_short_gate: best_gate[15:0]};
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/timestamp_kway_merge.sv -----
// ---------------------------------------------------------------------------
// timestamp_kway_merge: k-way merge of time-ordered channel event streams
// Per-channel event FIFOs merged into one stream ordered by timestamp.
// ---------------------------------------------------------------------------
// Each request transaction (push, close or pull) yields exactly one response
// transaction, in request order. Requests enter a two-entry command queue,
// so the request side keeps flowing while a response waits to be taken.
// Push, close and unknown requests finish in the cycle after they leave the
// queue. A pull walks the channels one at a time through the single read
// port of the event store: each channel is checked in S_SCAN, a channel with
// a head is read and compared in S_CMP, and S_FIN forms the response. Ties
// on timestamp go to the lowest channel. The user must write channel_enable
// through cfg_we/cfg_wdata only while the block is idle; it is not checked.
// Disabled channels keep their events but count as finished and empty.
// The store needs no clear after reset: entries are read only once written.
module timestamp_kway_merge #(
  parameter int CHANNELS   = tkm_pkg::CHANNELS_DEF,
  parameter int FIFO_DEPTH = tkm_pkg::FIFO_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tkm_pkg::ENABLE_BITS-1:0] cfg_wdata,
  tkm_req_if.sink                         req,
  tkm_rsp_if.source                       rsp
);
  import tkm_pkg::*;

  // channel_enable register, all channels on after reset
  logic [ENABLE_BITS-1:0] channel_enable;
  logic                   cmd_valid;
  logic                   cmd_pop;
  cmd_t                   cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_enable <= '1;
    end else if (cfg_we) begin
      channel_enable <= cfg_wdata;
    end
  end

  // decode and hold requests
  tkm_front #(.CHANNELS(CHANNELS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // execute commands, own FIFO state and the response register
  tkm_back #(.CHANNELS(CHANNELS), .FIFO_DEPTH(FIFO_DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .enable    (channel_enable),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .rsp       (rsp)
  );
endmodule

// ----- rtl/tkm_checker.sv -----
// ---------------------------------------------------------------------------
// tkm_checker: port-level checks for the merge block
// Response handshake and response field rules, bound to the top level.
// ---------------------------------------------------------------------------
module tkm_checker (
  input logic          clk,
  input logic          rst,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input tkm_pkg::rsp_t rsp_data
);
  import tkm_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_data))
    else $error("response changed while stalled");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status != ST_EVENT |->
      rsp_data.out_time == '0 && rsp_data.out_channel == '0 &&
      rsp_data.out_long_gate == '0 && rsp_data.out_short_gate == '0)
    else $error("event fields set on non-event response");

  a_no_sentinel: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status == ST_EVENT |-> rsp_data.out_time != SENTINEL)
    else $error("sentinel timestamp emitted");
endmodule

bind timestamp_kway_merge tkm_checker u_tkm_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);
